// ===== design/spsgc_pkg.sv =====
// Package for the bus phase sequencer with scatter/gather coalescing.
// Operation, phase, error and opcode codes, input word layout and controller commands.
// No dependencies.
package spsgc_pkg;

    localparam int OP_W        = 3;
    localparam int ERR_W       = 3;
    localparam int PHASE_W     = 2;
    localparam int STATUS_W    = 16;
    localparam int IDX_W       = 10;
    localparam int DATA_W      = 32;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam int IN_BITS     = 115;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_RESET    = 3'd0;
    localparam logic [OP_W-1:0] OP_ARB      = 3'd1;
    localparam logic [OP_W-1:0] OP_SELECT   = 3'd2;
    localparam logic [OP_W-1:0] OP_COMMAND  = 3'd3;
    localparam logic [OP_W-1:0] OP_XFER     = 3'd4;
    localparam logic [OP_W-1:0] OP_COMPLETE = 3'd5;
    localparam logic [OP_W-1:0] OP_STATUS   = 3'd6;
    localparam logic [OP_W-1:0] OP_READ     = 3'd7;

    localparam logic [PHASE_W-1:0] PH_FREE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ARB  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_SEL  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_XFER = 2'd3;

    localparam logic [ERR_W-1:0] E_OK    = 3'd0;
    localparam logic [ERR_W-1:0] E_COMM  = 3'd1;
    localparam logic [ERR_W-1:0] E_PARM  = 3'd2;
    localparam logic [ERR_W-1:0] E_PHASE = 3'd3;
    localparam logic [ERR_W-1:0] E_COMP  = 3'd4;
    localparam logic [ERR_W-1:0] E_BUSY  = 3'd5;
    localparam logic [ERR_W-1:0] E_SEQ   = 3'd6;
    localparam logic [ERR_W-1:0] E_FULL  = 3'd7;

    localparam logic [3:0] OPC_INC     = 4'd1;
    localparam logic [3:0] OPC_NOINC   = 4'd2;
    localparam logic [3:0] OPC_NOP_LO  = 4'd3;
    localparam logic [3:0] OPC_STOP    = 4'd7;
    localparam logic [3:0] OPC_COMPARE = 4'd8;

    localparam logic [3:0] CMD_LEN_6  = 4'd6;
    localparam logic [3:0] CMD_LEN_10 = 4'd10;
    localparam logic [3:0] CMD_LEN_12 = 4'd12;

    localparam logic [3:0] MAX_DEVICE_ID = 4'd7;

    localparam logic [STATUS_W-1:0] ST_FREE = 16'h0000;
    localparam logic [STATUS_W-1:0] ST_ARB  = 16'h0040;
    localparam logic [STATUS_W-1:0] ST_SEL  = 16'h006a;
    localparam logic [STATUS_W-1:0] ST_XFER = 16'h006e;

    // first member sits in the top bits, so the list runs from the last field down
    typedef struct packed {
        logic [IDX_W-1:0]    entry_index;
        logic [15:0]         device_status_in;
        logic                is_read;
        logic [DATA_W-1:0]   buffer_length;
        logic [DATA_W-1:0]   buffer_address;
        logic [3:0]          tib_opcode;
        logic [7:0]          command_byte1;
        logic [3:0]          command_length;
        logic                partner_ok;
        logic [3:0]          device_id;
        logic [OP_W-1:0]     operation;
    } in_item_t;

    typedef struct packed {
        logic exec;
        logic rd_start;
        logic rd_load;
    } ctrl_cmd_t;

    function automatic logic [STATUS_W-1:0] status_of(input logic [PHASE_W-1:0] ph);
        logic [STATUS_W-1:0] s;
        unique case (ph)
            PH_FREE: s = ST_FREE;
            PH_ARB:  s = ST_ARB;
            PH_SEL:  s = ST_SEL;
            PH_XFER: s = ST_XFER;
            default: s = ST_FREE;
        endcase
        return s;
    endfunction

endpackage

// ===== design/spsgc_ctrl.sv =====
// Controller for the phase sequencer: input/output handshake and the table read wait.
// Depends on spsgc_pkg.
module spsgc_ctrl
    import spsgc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] in_op,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output ctrl_cmd_t       cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RD   = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        accept       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                accept   = in_valid && in_ready;
                cmd.exec     = accept && (in_op != OP_READ);
                cmd.rd_start = accept && (in_op == OP_READ);
                if (cmd.rd_start)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.rd_load = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec || cmd.rd_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/spsgc_datapath.sv =====
// Datapath for the phase sequencer: phase and table state, the entry tables and result registers.
// Depends on spsgc_pkg; driven by spsgc_ctrl commands.
module spsgc_datapath
    import spsgc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    input  in_item_t            item,
    output logic [ERR_W-1:0]    error_code,
    output logic [STATUS_W-1:0] bus_status,
    output logic                manager_busy,
    output logic [2:0]          logical_unit,
    output logic [DATA_W-1:0]   next_address,
    output logic [DATA_W-1:0]   entry_address_out,
    output logic [DATA_W-1:0]   entry_length_out,
    output logic [CNT_W-1:0]    entry_count_out,
    output logic [DATA_W-1:0]   total_length_out,
    output logic                reading_out,
    output logic [15:0]         device_status_out
);

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int XW    = (AW > IDX_W) ? AW : IDX_W;
    localparam int CMP_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

    logic [DATA_W-1:0] addr_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] len_mem  [TABLE_DEPTH];

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               dir_reg, dir_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DATA_W-1:0]  total_reg, total_next;
    logic [DATA_W-1:0]  last_end_reg, last_end_next;
    logic [DATA_W-1:0]  last_len_reg, last_len_next;

    logic [ERR_W-1:0]   err_reg, err_c;
    logic [2:0]         lun_reg, lun_c;
    logic [DATA_W-1:0]  nxt_reg, nxt_c;
    logic [DATA_W-1:0]  ea_reg, el_reg;
    logic [15:0]        dso_reg, dso_c;

    logic               wr_addr_en, wr_len_en;
    logic [AW-1:0]      wr_idx;
    logic [DATA_W-1:0]  wr_len_val;
    logic [CNT_W-1:0]   count_m1;
    logic [DATA_W-1:0]  sum_al;
    logic               can_merge;

    logic [XW-1:0]      idx_ext;
    logic [CMP_W-1:0]   idx_cmp;
    logic               idx_ok_c, idx_ok_reg;
    logic [DATA_W-1:0]  rd_addr_reg, rd_len_reg;

    assign count_m1  = count_reg - CNT_W'(1);
    assign sum_al    = item.buffer_address + item.buffer_length;
    assign can_merge = (count_reg != '0) && (item.buffer_address == last_end_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        dir_next      = dir_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        last_end_next = last_end_reg;
        last_len_next = last_len_reg;
        err_c         = E_OK;
        lun_c         = '0;
        nxt_c         = '0;
        dso_c         = '0;
        wr_addr_en    = 1'b0;
        wr_len_en     = 1'b0;
        wr_idx        = count_reg[AW-1:0];
        wr_len_val    = item.buffer_length;
        unique case (item.operation)
            OP_RESET:
            begin
                phase_next = PH_FREE;
                count_next = '0;
            end
            OP_ARB:
            begin
                if (phase_reg != PH_FREE)
                begin
                    err_c = E_BUSY;
                end
                else
                begin
                    phase_next = PH_ARB;
                    dir_next   = 1'b0;
                    count_next = '0;
                    total_next = '0;
                end
            end
            OP_SELECT:
            begin
                priority if (phase_reg != PH_ARB)
                begin
                    err_c = E_SEQ;
                end
                else if ((item.device_id <= MAX_DEVICE_ID) && item.partner_ok)
                begin
                    phase_next = PH_SEL;
                end
                else
                begin
                    phase_next = PH_FREE;
                    err_c      = E_COMM;
                end
            end
            OP_COMMAND:
            begin
                lun_c = item.command_byte1[7:5];
                priority if (phase_reg != PH_SEL)
                begin
                    err_c = E_PHASE;
                end
                else if ((item.command_length != CMD_LEN_6)
                         && (item.command_length != CMD_LEN_10)
                         && (item.command_length != CMD_LEN_12))
                begin
                    err_c = E_PARM;
                end
                else if (!item.partner_ok)
                begin
                    phase_next = PH_FREE;
                    err_c      = E_COMM;
                end
                else
                begin
                    phase_next = PH_XFER;
                end
            end
            OP_XFER:
            begin
                if (phase_reg != PH_XFER)
                begin
                    err_c = E_PHASE;
                end
                else
                begin
                    if (item.is_read)
                    begin
                        dir_next = 1'b1;
                    end
                    priority if ((item.tib_opcode == OPC_INC)
                                 || (item.tib_opcode == OPC_NOINC))
                    begin
                        if (item.tib_opcode == OPC_INC)
                        begin
                            nxt_c = sum_al;
                        end
                        priority if (can_merge)
                        begin
                            // contiguous with the last entry: grow it
                            wr_len_en     = 1'b1;
                            wr_idx        = count_m1[AW-1:0];
                            wr_len_val    = last_len_reg + item.buffer_length;
                            last_len_next = wr_len_val;
                            last_end_next = last_end_reg + item.buffer_length;
                            total_next    = total_reg + item.buffer_length;
                        end
                        else if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            err_c = E_FULL;
                        end
                        else
                        begin
                            wr_addr_en    = 1'b1;
                            wr_len_en     = 1'b1;
                            last_len_next = item.buffer_length;
                            last_end_next = sum_al;
                            count_next    = count_reg + CNT_W'(1);
                            total_next    = total_reg + item.buffer_length;
                        end
                    end
                    else if ((item.tib_opcode >= OPC_NOP_LO)
                             && (item.tib_opcode <= OPC_STOP))
                    begin
                        err_c = E_OK;
                    end
                    else if (item.tib_opcode == OPC_COMPARE)
                    begin
                        err_c = E_COMP;
                    end
                    else
                    begin
                        err_c = E_PARM;
                    end
                end
            end
            OP_COMPLETE:
            begin
                if (phase_reg != PH_XFER)
                begin
                    err_c = E_PHASE;
                end
                else
                begin
                    dso_c      = item.device_status_in;
                    phase_next = PH_FREE;
                    err_c      = item.partner_ok ? E_OK : E_COMM;
                end
            end
            OP_STATUS:
            begin
                err_c = E_OK;
            end
            OP_READ:
            begin
                err_c = E_OK;
            end
            default:
            begin
                err_c = E_OK;
            end
        endcase
    end

    assign idx_ext  = XW'(item.entry_index);
    assign idx_cmp  = CMP_W'(item.entry_index);
    assign idx_ok_c = (idx_cmp < CMP_W'(count_reg)) && (idx_cmp < CMP_W'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_addr_en)
        begin
            addr_mem[wr_idx] <= item.buffer_address;
        end
        if (cmd.exec && wr_len_en)
        begin
            len_mem[wr_idx] <= wr_len_val;
        end
        if (cmd.rd_start)
        begin
            rd_addr_reg <= addr_mem[idx_ext[AW-1:0]];
            rd_len_reg  <= len_mem[idx_ext[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FREE;
            dir_reg   <= 1'b0;
            count_reg <= '0;
            total_reg <= '0;
        end
        else if (cmd.exec)
        begin
            phase_reg <= phase_next;
            dir_reg   <= dir_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.rd_start)
        begin
            idx_ok_reg <= idx_ok_c;
        end
        if (cmd.exec)
        begin
            last_end_reg <= last_end_next;
            last_len_reg <= last_len_next;
            err_reg      <= err_c;
            lun_reg      <= lun_c;
            nxt_reg      <= nxt_c;
            ea_reg       <= '0;
            el_reg       <= '0;
            dso_reg      <= dso_c;
        end
        else if (cmd.rd_load)
        begin
            err_reg <= E_OK;
            lun_reg <= '0;
            nxt_reg <= '0;
            ea_reg  <= idx_ok_reg ? rd_addr_reg : '0;
            el_reg  <= idx_ok_reg ? rd_len_reg : '0;
            dso_reg <= '0;
        end
    end

    // state only moves together with a result load, so it stands for the held result
    assign error_code        = err_reg;
    assign bus_status        = status_of(phase_reg);
    assign manager_busy      = (phase_reg != PH_FREE);
    assign logical_unit      = lun_reg;
    assign next_address      = nxt_reg;
    assign entry_address_out = ea_reg;
    assign entry_length_out  = el_reg;
    assign entry_count_out   = count_reg;
    assign total_length_out  = total_reg;
    assign reading_out       = dir_reg;
    assign device_status_out = dso_reg;

endmodule

// ===== design/scsi_phase_sequencer_sg_coalescer_top.sv =====
// Top level of the bus phase sequencer with scatter/gather coalescing.
// Depends on spsgc_pkg, spsgc_ctrl and spsgc_datapath.
//
// Usage:
//   Operations enter on the s_axis stream, one word per operation; each gives
//   exactly one result word on the m_axis stream.
//   Every operation but read entry takes one cycle: it is accepted, the phase
//   and table state update and the result register loads at the same edge,
//   so results appear one cycle after acceptance and a new operation may be
//   taken every cycle.
//   Read entry passes through a read-wait state: the entry tables are a registered-read
//   memory, so s_axis_tready drops for one cycle while the entry is fetched.
//   The result register is the only output storage; when m_axis_tready is low
//   and a result is held, s_axis_tready stays low until it is taken, and the
//   held result and the state it reports do not change.
//   After reset the bus is free, the table is empty, the byte total and the
//   direction flag are zero, and no result is pending. Table contents are not
//   cleared; entries beyond the count always read as zero.
module scsi_phase_sequencer_sg_coalescer_top
    import spsgc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1),
    parameter int OUT_BITS    = 168 + CNT_W,
    parameter int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // operation, device_id, partner_ok, command_length, command_byte1, tib_opcode,
    // buffer_address, buffer_length, is_read, device_status_in, entry_index
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // error_code, bus_status, manager_busy, logical_unit, next_address,
    // entry_address_out, entry_length_out, entry_count_out, total_length_out,
    // reading_out, device_status_out
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    in_item_t           item;
    ctrl_cmd_t          cmd;
    logic [ERR_W-1:0]    error_code;
    logic [STATUS_W-1:0] bus_status;
    logic                manager_busy;
    logic [2:0]          logical_unit;
    logic [DATA_W-1:0]   next_address;
    logic [DATA_W-1:0]   entry_address_out;
    logic [DATA_W-1:0]   entry_length_out;
    logic [CNT_W-1:0]    entry_count_out;
    logic [DATA_W-1:0]   total_length_out;
    logic                reading_out;
    logic [15:0]         device_status_out;

    assign item = in_item_t'(s_axis_tdata[IN_BITS-1:0]);

    spsgc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (item.operation),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    spsgc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CNT_W       (CNT_W)
    ) u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .item              (item),
        .error_code        (error_code),
        .bus_status        (bus_status),
        .manager_busy      (manager_busy),
        .logical_unit      (logical_unit),
        .next_address      (next_address),
        .entry_address_out (entry_address_out),
        .entry_length_out  (entry_length_out),
        .entry_count_out   (entry_count_out),
        .total_length_out  (total_length_out),
        .reading_out       (reading_out),
        .device_status_out (device_status_out)
    );

    assign m_axis_tdata = OUT_TDATA_W'({device_status_out, reading_out, total_length_out,
                                        entry_count_out, entry_length_out, entry_address_out,
                                        next_address, logical_unit, manager_busy,
                                        bus_status, error_code});

    // a read entry holds off the next word
    a_read_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (item.operation == OP_READ)) |=> !s_axis_tready)
        else $error("input accepted during table read");

    // every accepted word other than a read entry yields a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (item.operation != OP_READ)) |=> m_axis_tvalid)
        else $error("no result after accepted word");

    // entry count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_out <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // busy flag matches the reported bus status
    a_busy_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (manager_busy == (bus_status != ST_FREE)))
        else $error("busy flag and bus status disagree");

    // a held result does not change while the receiver stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("held result changed");

endmodule
